// ===== rtl/gc_pkg.sv =====
// Shared types and constants for the greedy graph coloring block.
package gc_pkg;

  localparam int FIELD_W = 7;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [FIELD_W-1:0] VERTEX_COUNT_RESET = 7'd64;
  localparam logic FUNC_COLOR = 1'b1;

  typedef enum logic {
    CMD_EDGE,
    CMD_COLOR
  } gc_kind_t;

  typedef struct packed {
    gc_kind_t kind;
    logic [FIELD_W-1:0] first_idx;
    logic [FIELD_W-1:0] second_idx;
  } gc_cmd_t;

endpackage

// ===== rtl/gc_front.sv =====
// Command front end: accepts items, drops out-of-range edges and queues the rest.
module gc_front #(
  parameter int MAX_VERTICES = gc_pkg::MAX_VERTICES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      func,
  input  logic [gc_pkg::FIELD_W-1:0] edge_first,
  input  logic [gc_pkg::FIELD_W-1:0] edge_second,
  output logic                      busy,
  output logic                      q_valid,
  output gc_pkg::gc_cmd_t           q_head,
  input  logic                      q_pop
);
  import gc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = ($clog2(MAX_VERTICES + 1) > FIELD_W) ?
                        $clog2(MAX_VERTICES + 1) : FIELD_W;

  gc_cmd_t          queue_mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic [CNTW-1:0]  count_next;
  logic             first_ok;
  logic             second_ok;
  logic             push;
  logic             pop_ok;
  gc_cmd_t          cmd;

  always_comb begin
    first_ok  = (edge_first != '0) && (CMPW'(edge_first) <= CMPW'(MAX_VERTICES));
    second_ok = (edge_second != '0) && (CMPW'(edge_second) <= CMPW'(MAX_VERTICES));
    cmd.kind       = (func == FUNC_COLOR) ? CMD_COLOR : CMD_EDGE;
    cmd.first_idx  = edge_first - FIELD_W'(1);
    cmd.second_idx = edge_second - FIELD_W'(1);
    busy   = (count == CNTW'(QUEUE_DEPTH));
    push   = start && !busy && ((func == FUNC_COLOR) || (first_ok && second_ok));
    pop_ok = q_pop && (count != '0);
    count_next = count + CNTW'(push) - CNTW'(pop_ok);
    q_valid = (count != '0);
    q_head  = queue_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= cmd;
    end
  end

endmodule

// ===== rtl/gc_back.sv =====
// Command back end: adjacency storage, edge writes and the first-fit coloring walk.
module gc_back #(
  parameter int MAX_VERTICES = gc_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [gc_pkg::FIELD_W-1:0] vertex_count,
  input  logic                       q_valid,
  input  gc_pkg::gc_cmd_t            q_head,
  output logic                       q_pop,
  output logic                       result_strobe,
  output logic [gc_pkg::FIELD_W-1:0] vertex,
  output logic [gc_pkg::FIELD_W-1:0] color,
  output logic                       last
);
  import gc_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CMPW = (NW > FIELD_W) ? NW : FIELD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE2,
    ST_ROW,
    ST_SCAN,
    ST_FIND
  } state_t;

  state_t                  state;
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [NW-1:0]           color_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_q;
  logic                    row_ok;
  logic [NW-1:0]           col_q;
  logic [VW-1:0]           e_first;
  logic [VW-1:0]           e_second;
  logic [VW-1:0]           v;
  logic [VW-1:0]           u;
  logic [VW-1:0]           u_d;
  logic                    pend;
  logic [NW-1:0]           n;
  logic [NW-1:0]           c;
  logic [MAX_VERTICES:0]   used;

  logic                    wr_en;
  logic [VW-1:0]           wr_addr;
  logic [VW-1:0]           wr_bit;
  logic [MAX_VERTICES-1:0] wr_onehot;
  logic                    clear_rows;
  logic                    row_rd;
  logic                    col_rd;
  logic                    emit;
  logic                    is_last;
  logic [NW-1:0]           n_sat;
  logic [CMPW-1:0]         vnum;
  logic [CMPW-1:0]         c_ext;

  always_comb begin
    n_sat = (CMPW'(vertex_count) > CMPW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) :
            NW'(vertex_count);
    vnum    = CMPW'(v) + CMPW'(1);
    c_ext   = CMPW'(c);
    is_last = (vnum == CMPW'(n));
    q_pop   = (state == ST_IDLE) && q_valid;
    wr_en   = 1'b0;
    wr_addr = VW'(q_head.first_idx);
    wr_bit  = VW'(q_head.second_idx);
    if (state == ST_IDLE && q_valid && q_head.kind == CMD_EDGE) begin
      wr_en = 1'b1;
    end else if (state == ST_EDGE2) begin
      wr_en   = 1'b1;
      wr_addr = e_second;
      wr_bit  = e_first;
    end
    wr_onehot = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << wr_bit;
    emit   = (state == ST_FIND) && !used[c];
    row_rd = (state == ST_ROW);
    col_rd = (state == ST_SCAN) && (u < v);
    clear_rows = (emit && is_last) ||
                 (state == ST_IDLE && q_valid && q_head.kind == CMD_COLOR && n_sat == '0);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (!row_valid[wr_addr]) begin
        adj_mem[wr_addr] <= wr_onehot;
      end else begin
        adj_mem[wr_addr][wr_bit] <= 1'b1;
      end
    end
    if (row_rd) begin
      row_q  <= adj_mem[v];
      row_ok <= row_valid[v];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      color_mem[v] <= c;
    end
    if (col_rd) begin
      col_q <= color_mem[u];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_rows) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_strobe <= 1'b0;
      pend          <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_head.kind == CMD_EDGE) begin
              e_first  <= VW'(q_head.first_idx);
              e_second <= VW'(q_head.second_idx);
              state    <= ST_EDGE2;
            end else begin
              n <= n_sat;
              v <= '0;
              if (n_sat != '0) begin
                state <= ST_ROW;
              end
            end
          end
        end
        ST_EDGE2: begin
          state <= ST_IDLE;
        end
        ST_ROW: begin
          u     <= '0;
          pend  <= 1'b0;
          used  <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (pend && row_ok && row_q[u_d]) begin
            used[col_q] <= 1'b1;
          end
          if (u < v) begin
            u_d  <= u;
            u    <= u + VW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              c     <= NW'(1);
              state <= ST_FIND;
            end
          end
        end
        ST_FIND: begin
          if (used[c]) begin
            c <= c + NW'(1);
          end else begin
            result_strobe <= 1'b1;
            vertex        <= vnum[FIELD_W-1:0];
            color         <= c_ext[FIELD_W-1:0];
            last          <= is_last;
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              v     <= v + VW'(1);
              state <= ST_ROW;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/greedy_graph_coloring.sv =====
// Top level of the greedy first-fit graph coloring block.
// Edge items transfer one per cycle while the four-entry queue has room; the back end
// retires each edge in ST_IDLE and then ST_EDGE2, one adjacency row write for each direction.
// A color run of n vertices gives one result per vertex, never stalled.
// Reset empties the queue, drops all edges and sets the vertex count to 64.
module greedy_graph_coloring #(
  parameter int MAX_VERTICES = gc_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       func,
  input  logic [gc_pkg::FIELD_W-1:0] edge_first,
  input  logic [gc_pkg::FIELD_W-1:0] edge_second,
  input  logic                       cfg_wen,
  input  logic [gc_pkg::FIELD_W-1:0] cfg_wdata,
  output logic                       result_strobe,
  output logic [gc_pkg::FIELD_W-1:0] vertex,
  output logic [gc_pkg::FIELD_W-1:0] color,
  output logic                       last
);
  import gc_pkg::*;

  logic [FIELD_W-1:0] vertex_count;
  logic               q_valid;
  logic               q_pop;
  gc_cmd_t            q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (cfg_wen) begin
      vertex_count <= cfg_wdata;
    end
  end

  gc_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .edge_first (edge_first),
    .edge_second(edge_second),
    .busy       (busy),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  gc_back #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .vertex_count (vertex_count),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_strobe(result_strobe),
    .vertex       (vertex),
    .color        (color),
    .last         (last)
  );

endmodule

// ===== bench/coloring_checker.sv =====
// Checker that predicts first-fit vertex colors and compares them with the block's results.
module coloring_checker #(
  parameter int MAX_VERTICES = gc_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       func,
  input  logic [gc_pkg::FIELD_W-1:0] edge_first,
  input  logic [gc_pkg::FIELD_W-1:0] edge_second,
  input  logic                       cfg_wen,
  input  logic [gc_pkg::FIELD_W-1:0] cfg_wdata,
  input  logic                       result_strobe,
  input  logic [gc_pkg::FIELD_W-1:0] vertex,
  input  logic [gc_pkg::FIELD_W-1:0] color,
  input  logic                       last,
  output int                         mismatches,
  output int                         colors_pending,
  output int                         colors_checked
);
  import gc_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] vertex;
    logic [FIELD_W-1:0] color;
    logic               last;
  } vertex_color_t;

  logic [MAX_VERTICES-1:0] neighbors [MAX_VERTICES];
  logic [FIELD_W-1:0]      vertex_limit;
  vertex_color_t           colors_due [$];

  function automatic void add_edge(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
    if (a >= 1 && a <= MAX_VERTICES && b >= 1 && b <= MAX_VERTICES) begin
      neighbors[a-1][b-1] = 1'b1;
      neighbors[b-1][a-1] = 1'b1;
    end
  endfunction

  // Colors vertices in ascending order, each with the lowest color its earlier
  // neighbors leave free, then drops the graph as the block does.
  function automatic void color_graph();
    int n;
    int c;
    int assigned [MAX_VERTICES];
    logic [MAX_VERTICES+1:0] taken;
    vertex_color_t entry;
    n = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_limit);
    foreach (assigned[i]) assigned[i] = 0;
    for (int v = 0; v < n; v++) begin
      taken = '0;
      for (int u = 0; u < n; u++) begin
        if (u != v && neighbors[v][u]) taken[assigned[u]] = 1'b1;
      end
      c = 1;
      while (c <= MAX_VERTICES && taken[c]) c++;
      assigned[v] = c;
      entry.vertex = FIELD_W'(v + 1);
      entry.color = FIELD_W'(c);
      entry.last = (v + 1 == n);
      colors_due.push_back(entry);
    end
    foreach (neighbors[i]) neighbors[i] = '0;
  endfunction

  function automatic void compare_field(string name, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    mismatches = 0;
    colors_pending = 0;
    colors_checked = 0;
  end

  always @(posedge clk) begin
    vertex_color_t want;
    if (rst) begin
      foreach (neighbors[i]) neighbors[i] = '0;
      vertex_limit = VERTEX_COUNT_RESET;
      colors_due.delete();
    end else begin
      if (result_strobe) begin
        if (colors_due.size() == 0) begin
          $error("unexpected result: vertex %0d color %0d last %0d", vertex, color, last);
          mismatches++;
        end else begin
          want = colors_due.pop_front();
          compare_field("vertex", want.vertex, vertex);
          compare_field("color", want.color, color);
          compare_field("last", FIELD_W'(want.last), FIELD_W'(last));
          colors_checked++;
        end
      end
      if (cfg_wen) vertex_limit = cfg_wdata;
      if (start && !busy) begin
        if (func == CMD_COLOR) color_graph();
        else add_edge(edge_first, edge_second);
      end
    end
    colors_pending = colors_due.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Stimulus and verdict for the greedy graph coloring block, checked by coloring_checker.
module testbench;
  import gc_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEM_TARGET = 280;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               func;
  logic [FIELD_W-1:0] edge_first;
  logic [FIELD_W-1:0] edge_second;
  logic               cfg_wen;
  logic [FIELD_W-1:0] cfg_wdata;
  logic               result_strobe;
  logic [FIELD_W-1:0] vertex;
  logic [FIELD_W-1:0] color;
  logic               last;

  int mismatches;
  int colors_pending;
  int colors_checked;
  int items_sent;
  int color_runs;
  int count_writes;
  int vertices_now;
  bit steady_sender;

  greedy_graph_coloring uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .edge_first(edge_first),
    .edge_second(edge_second),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .result_strobe(result_strobe),
    .vertex(vertex),
    .color(color),
    .last(last)
  );

  coloring_checker u_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .edge_first(edge_first),
    .edge_second(edge_second),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .result_strobe(result_strobe),
    .vertex(vertex),
    .color(color),
    .last(last),
    .mismatches(mismatches),
    .colors_pending(colors_pending),
    .colors_checked(colors_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || result_strobe) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("[greedy_graph_coloring] ERROR");
    $finish;
  end

  // Holds the item until its transfer, then leaves start high unless a gap follows.
  task automatic send_item(input gc_kind_t kind, input int a, input int b);
    int roll;
    int gap;
    start <= 1'b1;
    func <= kind;
    edge_first <= FIELD_W'(a);
    edge_second <= FIELD_W'(b);
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (kind == CMD_COLOR) color_runs++;
    items_sent++;
    if (!steady_sender) begin
      roll = $urandom_range(0, 99);
      gap = roll < 60 ? 0 : roll < 92 ? $urandom_range(1, 3) : $urandom_range(12, 60);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // The edge queue may still be draining after the last color, so wait a little longer.
  task automatic set_vertex_count(input int value);
    start <= 1'b0;
    while (colors_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= FIELD_W'(value);
    @(negedge clk);
    cfg_wen <= 1'b0;
    vertices_now = value > MAX_VERTICES_DEF ? MAX_VERTICES_DEF : value;
    count_writes++;
  endtask

  // Mostly edges packed into a narrow window so that cliques push colors up.
  task automatic random_phase();
    int edges;
    int hi;
    int lo;
    int span;
    int roll;
    int a;
    int b;
    edges = $urandom_range(0, 18);
    hi = vertices_now > 1 ? vertices_now : 2;
    lo = $urandom_range(1, hi);
    span = $urandom_range(1, 7);
    for (int k = 0; k < edges; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        a = lo + $urandom_range(0, span);
        b = lo + $urandom_range(0, span);
        if (a > MAX_VERTICES_DEF) a = MAX_VERTICES_DEF;
        if (b > MAX_VERTICES_DEF) b = MAX_VERTICES_DEF;
      end else if (roll < 88) begin
        a = $urandom_range(1, MAX_VERTICES_DEF);
        b = $urandom_range(1, MAX_VERTICES_DEF);
      end else begin
        a = $urandom_range(0, 127);
        b = $urandom_range(0, 127);
      end
      send_item(CMD_EDGE, a, b);
    end
    send_item(CMD_COLOR, $urandom_range(0, 127), $urandom_range(0, 127));
  endtask

  initial begin
    int roll;
    int pick;
    rst = 1'b1;
    start = 1'b0;
    func = CMD_EDGE;
    edge_first = '0;
    edge_second = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    items_sent = 0;
    color_runs = 0;
    count_writes = 0;
    vertices_now = MAX_VERTICES_DEF;
    steady_sender = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(CMD_EDGE, 1, 2);
    send_item(CMD_EDGE, 2, 3);
    send_item(CMD_EDGE, 3, 1);
    send_item(CMD_EDGE, 64, 1);
    send_item(CMD_EDGE, 63, 64);
    send_item(CMD_EDGE, 5, 5);
    send_item(CMD_EDGE, 2, 1);
    send_item(CMD_EDGE, 0, 5);
    send_item(CMD_EDGE, 9, 0);
    send_item(CMD_EDGE, 65, 3);
    send_item(CMD_EDGE, 127, 127);
    send_item(CMD_EDGE, 4, 64);
    send_item(CMD_COLOR, 0, 0);
    set_vertex_count(3);
    send_item(CMD_EDGE, 1, 2);
    send_item(CMD_EDGE, 2, 3);
    send_item(CMD_EDGE, 3, 10);
    send_item(CMD_COLOR, 127, 127);
    set_vertex_count(0);
    send_item(CMD_EDGE, 1, 2);
    send_item(CMD_COLOR, 0, 0);
    set_vertex_count(127);
    send_item(CMD_COLOR, 0, 0);
    set_vertex_count(1);
    send_item(CMD_EDGE, 1, 2);
    send_item(CMD_COLOR, 0, 0);
    set_vertex_count(64);

    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      steady_sender = roll < 20;
      if (roll % 3 == 0) begin
        pick = $urandom_range(0, 99);
        set_vertex_count(pick < 75 ? $urandom_range(2, 12) :
                         pick < 85 ? $urandom_range(13, 40) :
                         pick < 90 ? MAX_VERTICES_DEF :
                         pick < 95 ? $urandom_range(0, 1) : $urandom_range(65, 127));
      end
      random_phase();
    end

    start <= 1'b0;
    while (colors_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Sent %0d edge and color items over %0d coloring runs and %0d vertex counts.",
             items_sent, color_runs, count_writes);
    $display("Checked %0d vertex colors.", colors_checked);
    if (mismatches == 0) begin
      $display("[greedy_graph_coloring] OK");
    end else begin
      $display("[greedy_graph_coloring] ERROR");
    end
    $finish;
  end

endmodule
